// ===== rtl/plc_pkg.sv =====
// Shared types and codes for the positional circular list engine.
package plc_pkg;

  // Operation codes carried on the request tuser
  typedef enum logic [2:0] {
    OP_RESET     = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_END   = 3'd2,
    OP_INS_POS   = 3'd3,
    OP_DEL_FRONT = 3'd4,
    OP_DEL_END   = 3'd5,
    OP_DEL_POS   = 3'd6,
    OP_DISPLAY   = 3'd7
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Field widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned IN_W    = 40;
  localparam int unsigned OUT_W   = 40;

endpackage

// ===== rtl/plc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module plc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/positional_circular_list_engine_top.sv =====
// Top level of the positional circular list engine.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values in one RAM.
// Requests arrive on the s_ channel: opcode in s_tuser, value and one-based
// position in s_tdata. Results leave on the m_ channel: status and element
// in m_tdata, with m_tlast on the final result of each request.
// One request is in flight at a time; s_tready is high only while idle,
// which is the cycle after the final result of a request is loaded.
// Edits run on a small sequencer around the single RAM port pair, moving
// one element at a time (a read, then a write of the element one place over).
// Reset to one and the inserts shift, then write the new value; deletes
// shift only, and an end delete moves no element.
// Display reads each element from the RAM, then loads it as a result.
// Errors (bad position, empty, full) go straight to the result with no change.
// The result register lets the next request be taken while the last
// result still waits; a stalled receiver holds m_tdata and stalls the
// sequencer only when a new result is due.
// Synchronous reset empties the list at once; RAM contents stay undefined
// and are never read before being written.
module positional_circular_list_engine_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [plc_pkg::IN_W-1:0]   s_tdata,   // value[31:0], position[39:32]
  input  logic [plc_pkg::OP_W-1:0]   s_tuser,   // opcode[2:0]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [plc_pkg::OUT_W-1:0]  m_tdata,   // status[1:0], element[33:2], zero[39:34]
  output logic                       m_tlast
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = ((LW > plc_pkg::POS_W) ? LW : plc_pkg::POS_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_ISH_RD, S_ISH_WR, S_PUT, S_DSH_RD, S_DSH_WR, S_RESP, S_DRD, S_DOUT
  } state_t;

  state_t                         state;
  logic [LW-1:0]                  length;
  logic [LW-1:0]                  len_new;
  logic [LW-1:0]                  cur;
  logic [LW-1:0]                  tgt;
  logic [plc_pkg::VALUE_W-1:0]    val;
  plc_pkg::status_t               rsp_status;
  plc_pkg::status_t               out_status;
  logic [plc_pkg::VALUE_W-1:0]    out_element;

  // Request decode
  plc_pkg::op_t                   op;
  logic [plc_pkg::VALUE_W-1:0]    in_value;
  logic [CW-1:0]                  pos_x;
  logic [CW-1:0]                  len_x;
  logic [LW-1:0]                  pos_idx;
  logic                           full;
  logic                           empty;
  plc_pkg::status_t               d_status;
  state_t                         d_state;
  logic [LW-1:0]                  d_cur;
  logic [LW-1:0]                  d_tgt;
  logic [LW-1:0]                  d_len;

  // Shared pointer arithmetic
  logic [LW-1:0]                  cur_inc;
  logic [LW-1:0]                  cur_dec;
  logic [LW-1:0]                  cur_inc2;
  logic                           out_free;
  logic                           res_load;

  // RAM port controls
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [plc_pkg::VALUE_W-1:0]    ram_wdata;
  logic                           ram_re;
  logic [AW-1:0]                  ram_raddr;
  logic [plc_pkg::VALUE_W-1:0]    ram_rdata;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {{(plc_pkg::OUT_W - plc_pkg::VALUE_W - plc_pkg::STAT_W){1'b0}},
                     out_element, out_status};
  assign out_free = !m_tvalid || m_tready;
  assign res_load = ((state == S_RESP) || (state == S_DOUT)) && out_free;

  assign op       = plc_pkg::op_t'(s_tuser);
  assign in_value = s_tdata[plc_pkg::VALUE_W-1:0];
  assign pos_x    = CW'(s_tdata[plc_pkg::VALUE_W +: plc_pkg::POS_W]);
  assign len_x    = CW'(length);
  assign pos_idx  = LW'(pos_x - CW'(1));
  assign full     = (length == LW'(CAPACITY));
  assign empty    = (length == '0);

  assign cur_inc  = cur + LW'(1);
  assign cur_dec  = cur - LW'(1);
  assign cur_inc2 = cur_inc + LW'(1);

  // Check the request and pick the first sequencer step
  always_comb begin
    d_status = plc_pkg::ST_OK;
    d_state  = S_RESP;
    d_cur    = '0;
    d_tgt    = '0;
    d_len    = length;
    unique case (op) inside
      plc_pkg::OP_RESET: begin
        d_state = S_PUT;
        d_len   = LW'(1);
      end
      plc_pkg::OP_INS_FRONT, plc_pkg::OP_INS_END, plc_pkg::OP_INS_POS: begin
        if (op == plc_pkg::OP_INS_FRONT) begin
          d_tgt = '0;
        end else if (op == plc_pkg::OP_INS_END) begin
          d_tgt = length;
        end else begin
          d_tgt = pos_idx;
        end
        if (op == plc_pkg::OP_INS_POS && (pos_x == '0 || pos_x > len_x + CW'(1))) begin
          d_status = plc_pkg::ST_BADPOS;
        end else if (full) begin
          d_status = plc_pkg::ST_FULL;
        end else begin
          d_cur   = length;
          d_len   = length + LW'(1);
          d_state = (length > d_tgt) ? S_ISH_RD : S_PUT;
        end
      end
      plc_pkg::OP_DEL_FRONT, plc_pkg::OP_DEL_END, plc_pkg::OP_DEL_POS: begin
        if (op == plc_pkg::OP_DEL_FRONT) begin
          d_cur = '0;
        end else if (op == plc_pkg::OP_DEL_END) begin
          d_cur = length - LW'(1);
        end else begin
          d_cur = pos_idx;
        end
        if (op != plc_pkg::OP_DEL_POS && empty) begin
          d_status = plc_pkg::ST_EMPTY;
        end else if (op == plc_pkg::OP_DEL_POS && pos_x == CW'(1) && empty) begin
          d_status = plc_pkg::ST_EMPTY;
        end else if (op == plc_pkg::OP_DEL_POS && (pos_x == '0 || pos_x > len_x)) begin
          d_status = plc_pkg::ST_BADPOS;
        end else begin
          d_len   = length - LW'(1);
          d_state = (d_cur + LW'(1) < length) ? S_DSH_RD : S_RESP;
        end
      end
      plc_pkg::OP_DISPLAY: begin
        if (empty) begin
          d_status = plc_pkg::ST_EMPTY;
        end else begin
          d_state = S_DRD;
        end
      end
      default: begin
        d_state = S_RESP;
      end
    endcase
  end

  // Drive the RAM from the sequencer step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur[AW-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = cur[AW-1:0];
    unique case (state)
      S_ISH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cur_dec[AW-1:0];
      end
      S_ISH_WR, S_DSH_WR: begin
        ram_we = 1'b1;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = tgt[AW-1:0];
        ram_wdata = val;
      end
      S_DSH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cur_inc[AW-1:0];
      end
      S_DRD: begin
        ram_re = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer, list length and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      length   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state      <= d_state;
            cur        <= d_cur;
            tgt        <= d_tgt;
            len_new    <= d_len;
            val        <= in_value;
            rsp_status <= d_status;
          end
        end
        S_ISH_RD: begin
          state <= S_ISH_WR;
        end
        S_ISH_WR: begin
          cur   <= cur_dec;
          state <= (cur_dec > tgt) ? S_ISH_RD : S_PUT;
        end
        S_PUT: begin
          state <= S_RESP;
        end
        S_DSH_RD: begin
          state <= S_DSH_WR;
        end
        S_DSH_WR: begin
          cur   <= cur_inc;
          state <= (cur_inc2 < length) ? S_DSH_RD : S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            length      <= len_new;
            out_status  <= rsp_status;
            out_element <= '0;
            m_tlast     <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_DRD: begin
          state <= S_DOUT;
        end
        S_DOUT: begin
          if (out_free) begin
            out_status  <= plc_pkg::ST_OK;
            out_element <= ram_rdata;
            m_tlast     <= (cur_inc == length);
            cur         <= cur_inc;
            state       <= (cur_inc == length) ? S_IDLE : S_DRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  plc_ram #(
    .WIDTH (plc_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/plc_checker.sv =====
// Port-level checks for the positional circular list engine, bound to the top level.
module plc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [plc_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tlast
);

  // A taken request keeps the engine busy in the following cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("engine ready right after taking a request");

  // Hold a stalled result
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

  // Keep the request side closed while a display burst is still going
  a_burst_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> !s_tready)
    else $error("request taken in the middle of a display burst");

  // Error results are single, final and carry no element
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != plc_pkg::ST_OK) |->
      (m_tlast && m_tdata[33:2] == '0))
    else $error("error result not final or element not zero");

endmodule

bind positional_circular_list_engine_top plc_checker u_plc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
